// File: hw/rtl/raycast_column_span_setup_core_macros.svh
// Assertion macros shared by the checker of the column span setup core.
// Depends on nothing; included by the checker file only.
`ifndef RAYCAST_COLUMN_SPAN_SETUP_CORE_MACROS_SVH
`define RAYCAST_COLUMN_SPAN_SETUP_CORE_MACROS_SVH

// Implication checked outside reset.
`define RCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included.
`define RCS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/rcs_pkg.sv
// Shared types, constants and helper functions of the column span setup core.
// Depends on nothing; imported by every RTL module of the block.
package rcs_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int ROW_W         = 13;
  localparam int DIV_STEPS     = 32;
  localparam int TEX_W         = 13;
  localparam int DIFF_W        = 17;

  localparam logic [31:0] LH_MIN    = 32'h0001_0000;
  localparam logic [31:0] LH_MAX    = 32'hFFFF_FFFF;
  localparam logic [23:0] ADDR_MAX  = 24'hFF_FFFF;
  localparam logic [31:0] START_MAX = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_TEX_STRIDE = 2'd2
  } reg_idx_t;

  // Item moving through one restoring division cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [31:0] dvsr;
    logic [31:0] quo;
  } rcs_div_t;

  // Integer part of a Q.17 value, rounding toward zero.
  function automatic logic signed [35:0] trunc_q17(input logic signed [35:0] v);
    logic signed [35:0] neg;
    neg = -v;
    if (v >= 0) begin
      trunc_q17 = v >>> 17;
    end else begin
      trunc_q17 = -(neg >>> 17);
    end
  endfunction

  // Clamp a row number to the screen.
  function automatic logic [ROW_W-1:0] clamp_rows(input logic signed [35:0] v);
    if (v < 0) begin
      clamp_rows = '0;
    end else if (v > 36'(SCREEN_HEIGHT)) begin
      clamp_rows = ROW_W'(SCREEN_HEIGHT);
    end else begin
      clamp_rows = v[ROW_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/raycast_column_span_setup_core.sv
// Top level of the wall column span setup core.
// Depends on rcs_pkg, rcs_divider and rcs_div_cell.
//
// One ray hit is taken per clock cycle whenever start is high and busy is low;
// busy is high only during reset and in the cycle after it. Each hit gives
// exactly one result, shown for one cycle with done high. The hit passes
// through two chains of 32 division cells (line height, then texel step)
// plus six registered stages after the input register. The receiver cannot
// stall the block, so results must be taken when done is high. The user must
// write texture registers over the APB port only while no hit is in flight;
// the block itself does not enforce this.
module raycast_column_span_setup_core
  import rcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] wall_distance,
  input  logic [15:0] hit_u,
  input  logic [7:0]  wall_kind,
  input  logic [1:0]  wall_face,
  input  logic signed [16:0] view_offset,
  output logic        done,
  output logic [12:0] first_row,
  output logic [12:0] end_row,
  output logic        span_empty,
  output logic [7:0]  out_kind,
  output logic [1:0]  out_face,
  output logic [23:0] texel_column_address,
  output logic [31:0] texel_start,
  output logic [31:0] texel_step,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic               sat;
    logic [7:0]         kind;
    logic [1:0]         face;
    logic signed [16:0] off;
    logic [23:0]        addr;
  } side1_t;

  typedef struct packed {
    logic [ROW_W-1:0]  first;
    logic [ROW_W-1:0]  last;
    logic              empty;
    logic [7:0]        kind;
    logic [1:0]        face;
    logic [23:0]       addr;
    logic [DIFF_W-1:0] diff;
  } side2_t;

  logic [TEX_W-1:0] tex_width;
  logic [TEX_W-1:0] tex_height;
  logic [TEX_W-1:0] tex_stride;

  // Configuration registers and read back.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= TEX_W'(64);
      tex_height <= TEX_W'(64);
      tex_stride <= TEX_W'(64);
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TEX_WIDTH:  tex_width  <= pwdata[TEX_W-1:0];
        REG_TEX_HEIGHT: tex_height <= pwdata[TEX_W-1:0];
        REG_TEX_STRIDE: tex_stride <= pwdata[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_TEX_WIDTH:  prdata = 32'(tex_width);
      REG_TEX_HEIGHT: prdata = 32'(tex_height);
      REG_TEX_STRIDE: prdata = 32'(tex_stride);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Busy only right after reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 0: input item register.
  logic               v0;
  logic [23:0]        dist0;
  logic [15:0]        u0;
  logic [7:0]         kind0;
  logic [1:0]         face0;
  logic signed [16:0] off0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dist0 <= wall_distance;
    u0    <= hit_u;
    kind0 <= wall_kind;
    face0 <= wall_face;
    off0  <= view_offset;
  end

  // Stage 1: texel column from the horizontal hit coordinate.
  logic               v1;
  logic [23:0]        dist1;
  logic [7:0]         kind1;
  logic [1:0]         face1;
  logic signed [16:0] off1;
  logic [TEX_W-1:0]   col1;
  logic [28:0]        col_prod;

  assign col_prod = 29'(u0) * 29'(tex_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    dist1 <= dist0;
    kind1 <= kind0;
    face1 <= face0;
    off1  <= off0;
    col1  <= col_prod[28:16];
  end

  // Stage 2: saturating column address and line height overflow flag.
  logic               v2;
  logic [23:0]        dist2;
  side1_t             side2_in;
  logic [25:0]        addr_prod;

  assign addr_prod = 26'(col1) * 26'(tex_stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dist2         <= dist1;
    side2_in.sat  <= dist1 <= 24'(SCREEN_HEIGHT);
    side2_in.kind <= kind1;
    side2_in.face <= face1;
    side2_in.off  <= off1;
    side2_in.addr <= (|addr_prod[25:24]) ? ADDR_MAX : addr_prod[23:0];
  end

  // Line height division: screen height over distance.
  rcs_div_t div1_in;
  rcs_div_t div1_out;
  side1_t   side1_line [DIV_STEPS];

  always_comb begin
    div1_in.valid = v2;
    div1_in.rem   = side2_in.sat ? 32'd0 : 32'(SCREEN_HEIGHT);
    div1_in.dvsr  = 32'(dist2);
    div1_in.quo   = '0;
  end

  rcs_divider u_div_height (
    .clk  (clk),
    .rst  (rst),
    .din  (div1_in),
    .dout (div1_out)
  );

  always_ff @(posedge clk) begin
    side1_line[0] <= side2_in;
    for (int i = 1; i < DIV_STEPS; i++) begin
      side1_line[i] <= side1_line[i-1];
    end
  end

  // Stage 3: saturated line height and unclamped top and bottom.
  logic               v3;
  logic [31:0]        lh3;
  logic signed [35:0] top3;
  logic signed [35:0] bot3;
  side1_t             s3;
  logic [31:0]        lh_raw;
  logic [31:0]        lh_fix;
  logic signed [35:0] off_ext;
  logic signed [35:0] off_q17;

  always_comb begin
    lh_raw  = side1_line[DIV_STEPS-1].sat ? LH_MAX : div1_out.quo;
    lh_fix  = (lh_raw < LH_MIN) ? LH_MIN : lh_raw;
    off_ext = 36'(side1_line[DIV_STEPS-1].off);
    off_q17 = off_ext <<< 13;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= div1_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    lh3  <= lh_fix;
    s3   <= side1_line[DIV_STEPS-1];
    top3 <= (36'(SCREEN_HEIGHT) <<< 16) - $signed(36'(lh_fix)) - off_q17;
    bot3 <= (36'(SCREEN_HEIGHT) <<< 16) + $signed(36'(lh_fix)) - off_q17;
  end

  // Stage 4: clamped rows and the row distance for the texel start.
  logic               v4;
  logic [31:0]        lh4;
  side2_t             s4;
  logic signed [35:0] top_trunc;
  logic signed [35:0] first_ext;
  logic signed [35:0] row_diff;
  logic [ROW_W-1:0]   first_c;
  logic [ROW_W-1:0]   end_c;

  always_comb begin
    top_trunc = trunc_q17(top3);
    first_c   = (top3 < 0) ? '0 : clamp_rows(top3 >>> 17);
    end_c     = clamp_rows(trunc_q17(bot3));
    first_ext = 36'(first_c);
    row_diff  = first_ext - top_trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    lh4      <= lh3;
    s4.first <= first_c;
    s4.last  <= end_c;
    s4.empty <= first_c >= end_c;
    s4.kind  <= s3.kind;
    s4.face  <= s3.face;
    s4.addr  <= s3.addr;
    s4.diff  <= (row_diff > 0) ? row_diff[DIFF_W-1:0] : '0;
  end

  // Texel step division: texture height over line height.
  rcs_div_t div2_in;
  rcs_div_t div2_out;
  side2_t   side2_line [DIV_STEPS];

  always_comb begin
    div2_in.valid = v4;
    div2_in.rem   = 32'(tex_height);
    div2_in.dvsr  = lh4;
    div2_in.quo   = '0;
  end

  rcs_divider u_div_step (
    .clk  (clk),
    .rst  (rst),
    .din  (div2_in),
    .dout (div2_out)
  );

  always_ff @(posedge clk) begin
    side2_line[0] <= s4;
    for (int i = 1; i < DIV_STEPS; i++) begin
      side2_line[i] <= side2_line[i-1];
    end
  end

  // Stage 5: texel start product.
  logic        v5;
  logic [31:0] step5;
  logic [48:0] start_prod;
  side2_t      s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= div2_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    step5      <= div2_out.quo;
    start_prod <= 49'(div2_out.quo) * 49'(side2_line[DIV_STEPS-1].diff);
    s5         <= side2_line[DIV_STEPS-1];
  end

  // Stage 6: result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    first_row            <= s5.first;
    end_row              <= s5.last;
    span_empty           <= s5.empty;
    out_kind             <= s5.kind;
    out_face             <= s5.face;
    texel_column_address <= s5.addr;
    texel_step           <= step5;
    texel_start          <= (|start_prod[48:32]) ? START_MAX : start_prod[31:0];
  end

endmodule

// File: hw/rtl/rcs_div_cell.sv
// One cell of the division chain: resolves one quotient bit per item.
// Depends on rcs_pkg.
module rcs_div_cell
  import rcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rcs_div_t din,
  output rcs_div_t dout
);

  logic [32:0] shifted;
  logic [32:0] trial;
  logic        take;
  rcs_div_t    cell_next;

  // Shift in a zero bit and subtract the divisor when it fits.
  always_comb begin
    shifted   = {din.rem, 1'b0};
    trial     = shifted - {1'b0, din.dvsr};
    take      = shifted >= {1'b0, din.dvsr};
    cell_next = din;
    cell_next.rem = take ? trial[31:0] : shifted[31:0];
    cell_next.quo = {din.quo[30:0], take};
  end

  // Only the valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem  <= cell_next.rem;
    dout.dvsr <= cell_next.dvsr;
    dout.quo  <= cell_next.quo;
  end

endmodule

// File: hw/rtl/rcs_divider.sv
// Pipelined 32-bit quotient divider built from a row of division cells.
// Depends on rcs_pkg and rcs_div_cell.
module rcs_divider
  import rcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  rcs_div_t din,
  output rcs_div_t dout
);

  rcs_div_t link [DIV_STEPS+1];

  assign link[0] = din;

  // Each cell hands its partial remainder to the next one every cycle.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rcs_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[DIV_STEPS];

endmodule

// File: hw/rtl/rcs_checker.sv
// Port-level checker of the column span setup core, bound to the top level.
// Depends on rcs_pkg and raycast_column_span_setup_core_macros.svh.
`include "raycast_column_span_setup_core_macros.svh"

module rcs_checker
  import rcs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [12:0] first_row,
  input logic [12:0] end_row,
  input logic        span_empty
);

  // No result is shown right after reset.
  `RCS_ASSERT_ALWAYS(a_no_done_after_rst, clk, $past(rst), !done, "result after reset")

  // Busy only in the cycle that follows reset.
  `RCS_ASSERT_ALWAYS(a_busy_only_after_rst, clk, !rst && !$past(rst), !busy, "busy while idle")

  // The empty flag agrees with the rows.
  `RCS_ASSERT_IMPL(a_empty_flag, clk, rst, done, span_empty == (first_row >= end_row), "bad empty flag")

  // Rows stay on the screen.
  `RCS_ASSERT_IMPL(a_rows_range, clk, rst, done, (first_row <= 13'(SCREEN_HEIGHT)) && (end_row <= 13'(SCREEN_HEIGHT)), "row off screen")

endmodule

bind raycast_column_span_setup_core rcs_checker u_rcs_checker (.*);
